// ----- hw/rtl/lepg_pkg.sv -----
// Package for the Lorenz Euler point generator: microcode table, operand and
// destination codes, register map and reset values.
// Depends on nothing; used by lorenz_euler_point_generator_core.
`timescale 1ns / 1ps

package lepg_pkg;

    // Configuration register map (word index on the APB port).
    localparam int AddrW = 5;

    typedef enum logic [2:0] {
        REG_SIGMA  = 3'd0,
        REG_BETA   = 3'd1,
        REG_RHO    = 3'd2,
        REG_DT     = 3'd3,
        REG_CSTART = 3'd4,
        REG_CEND   = 3'd5,
        REG_RSCALE = 3'd6,
        REG_COUNT  = 3'd7
    } reg_idx_t;

    // Reset values of the registers and the start point of a trajectory.
    localparam logic signed [31:0] SIGMA_RST  = 32'sd167772160;
    localparam logic signed [31:0] BETA_RST   = 32'sd44739243;
    localparam logic signed [31:0] RHO_RST    = 32'sd469762048;
    localparam logic [30:0]        DT_RST     = 31'd167772;
    localparam logic [23:0]        COLOR_RST  = 24'd0;
    localparam logic [31:0]        RSCALE_RST = 32'd0;
    localparam logic [16:0]        COUNT_RST  = 17'd65536;
    localparam logic signed [31:0] INIT_X     = 32'sd167772;

    // Operand sources of the datapath. Q is the Q8.24 product, P the low
    // product bits and R the product scaled down by 2^32.
    typedef enum logic [4:0] {
        SRC_ZERO  = 5'd0,
        SRC_X     = 5'd1,
        SRC_Y     = 5'd2,
        SRC_Z     = 5'd3,
        SRC_T0    = 5'd4,
        SRC_T1    = 5'd5,
        SRC_T2    = 5'd6,
        SRC_SIGMA = 5'd7,
        SRC_BETA  = 5'd8,
        SRC_RHO   = 5'd9,
        SRC_DT    = 5'd10,
        SRC_RS    = 5'd11,
        SRC_IDX   = 5'd12,
        SRC_DR    = 5'd13,
        SRC_DG    = 5'd14,
        SRC_DB    = 5'd15,
        SRC_C1R   = 5'd16,
        SRC_C1G   = 5'd17,
        SRC_C1B   = 5'd18,
        SRC_Q     = 5'd19,
        SRC_P     = 5'd20,
        SRC_R     = 5'd21
    } src_t;

    localparam int NumSrc = 22;

    // Write-back targets of the adder.
    typedef enum logic [3:0] {
        DST_NONE  = 4'd0,
        DST_X     = 4'd1,
        DST_Y     = 4'd2,
        DST_Z     = 4'd3,
        DST_T0    = 4'd4,
        DST_T1    = 4'd5,
        DST_T2    = 4'd6,
        DST_RED   = 4'd7,
        DST_GREEN = 4'd8,
        DST_BLUE  = 4'd9
    } dst_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // One control word: a multiplier issue and an adder issue per step.
    typedef struct packed {
        logic    mul_en;
        src_t    mul_a;
        src_t    mul_b;
        alu_op_t alu_op;
        src_t    alu_a;
        src_t    alu_b;
        dst_t    dst;
        logic    fin;
    } ucode_t;

    localparam int UcodeLen = 15;

    // Program for one Euler step plus the color ramp. The multiplier result
    // lands in the product register and is read from there by a later step.
    localparam ucode_t UCODE [UcodeLen] = '{
        '{1'b1, SRC_X,     SRC_Y,    ALU_SUB, SRC_Y,    SRC_X,    DST_T0,    1'b0},
        '{1'b1, SRC_SIGMA, SRC_T0,   ALU_ADD, SRC_Q,    SRC_ZERO, DST_T2,    1'b0},
        '{1'b1, SRC_BETA,  SRC_Z,    ALU_ADD, SRC_Q,    SRC_ZERO, DST_T0,    1'b0},
        '{1'b1, SRC_T0,    SRC_DT,   ALU_SUB, SRC_T2,   SRC_Q,    DST_T2,    1'b0},
        '{1'b1, SRC_T2,    SRC_DT,   ALU_ADD, SRC_Q,    SRC_ZERO, DST_T0,    1'b0},
        '{1'b0, SRC_ZERO,  SRC_ZERO, ALU_SUB, SRC_RHO,  SRC_Z,    DST_T1,    1'b0},
        '{1'b1, SRC_X,     SRC_T1,   ALU_ADD, SRC_Z,    SRC_Q,    DST_Z,     1'b0},
        '{1'b1, SRC_DR,    SRC_IDX,  ALU_SUB, SRC_Q,    SRC_Y,    DST_T1,    1'b0},
        '{1'b1, SRC_P,     SRC_RS,   ALU_ADD, SRC_X,    SRC_T0,   DST_X,     1'b0},
        '{1'b1, SRC_T1,    SRC_DT,   ALU_ADD, SRC_C1R,  SRC_R,    DST_RED,   1'b0},
        '{1'b1, SRC_DG,    SRC_IDX,  ALU_ADD, SRC_Y,    SRC_Q,    DST_Y,     1'b0},
        '{1'b1, SRC_P,     SRC_RS,   ALU_ADD, SRC_ZERO, SRC_ZERO, DST_NONE,  1'b0},
        '{1'b1, SRC_DB,    SRC_IDX,  ALU_ADD, SRC_C1G,  SRC_R,    DST_GREEN, 1'b0},
        '{1'b1, SRC_P,     SRC_RS,   ALU_ADD, SRC_ZERO, SRC_ZERO, DST_NONE,  1'b0},
        '{1'b0, SRC_ZERO,  SRC_ZERO, ALU_ADD, SRC_C1B,  SRC_R,    DST_BLUE,  1'b1}
    };

    // Saturate a wide signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [41:0] hi;
        logic signed [41:0] lo;
        hi = 42'sd2147483647;
        lo = -42'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end
        if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Clamp a signed color sum to 0..255.
    function automatic logic [7:0] clamp8(input logic signed [33:0] v);
        if (v < 34'sd0) begin
            return 8'd0;
        end
        if (v > 34'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage

// ----- hw/rtl/lorenz_euler_point_generator_core.sv -----
// Lorenz attractor point generator: one forward Euler step per input transfer.
// Microcoded datapath with one shared 33x33 multiplier and one saturating adder.
// Depends on lepg_pkg.
//
// Usage:
//   The input channel (in_valid, in_ready, restart) carries one tick per
//   transfer. When restart is 1 the position reloads to (0.01, 0, 0) and the
//   point index to 0 before the step. The output channel (out_valid,
//   out_ready) returns the new Q8.24 position, the ramp color, the point
//   index and a last-point flag, one result per input transfer.
//   The APB port sets sigma, beta, rho, the step size, the two colors, the
//   ramp scale and the point count; write it only while the block is idle.
//   An input transfer starts the 15-step microcode program on the single
//   multiplier; the sequencer then passes the result to the output register
//   in its hand-off state and returns to idle, where the next input transfer
//   is taken, so a new tick is not accepted while a step is in progress.
//   A finished result waits in the output register while the next input
//   transfer is taken and stepped; if the receiver still stalls when that
//   step completes, the sequencer holds in its hand-off state.
//   Reset loads the register defaults and the start point, and empties the
//   output register.
`timescale 1ns / 1ps

module lorenz_euler_point_generator_core #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    // Output channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            pos_x,
    output logic signed [31:0]            pos_y,
    output logic signed [31:0]            pos_z,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue,
    output logic [15:0]                   step_index,
    output logic                          last_point,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lepg_pkg::AddrW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic [16:0] MaxCnt = 17'(MAX_POINTS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    // Configuration registers.
    logic signed [31:0] sigma_reg;
    logic signed [31:0] beta_reg;
    logic signed [31:0] rho_reg;
    logic [30:0]        dt_reg;
    logic [23:0]        cstart_reg;
    logic [23:0]        cend_reg;
    logic [31:0]        rscale_reg;
    logic [16:0]        count_reg;

    // Sequencer and datapath registers.
    state_t                 state_reg, state_next;
    logic [3:0]             step_reg, step_next;
    logic signed [31:0]     cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [31:0]     t0_reg, t1_reg, t2_reg;
    logic [7:0]             cr_reg, cg_reg, cb_reg;
    logic [15:0]            idx_reg;
    logic signed [65:0]     prod_reg;

    // Output register.
    logic                   out_valid_reg;
    logic signed [31:0]     pos_x_reg, pos_y_reg, pos_z_reg;
    logic [7:0]             red_reg, green_reg, blue_reg;
    logic [15:0]            index_reg;
    logic                   last_reg;

    lepg_pkg::ucode_t                     uc;
    logic [lepg_pkg::NumSrc-1:0][32:0]    src_bus;
    logic signed [32:0]                   mul_a_val, mul_b_val;
    logic signed [32:0]                   alu_a_val, alu_b_val;
    logic signed [33:0]                   alu_sum;
    logic signed [31:0]                   alu_sat;
    logic signed [31:0]                   q_val;
    logic signed [8:0]                    dr, dg, db;
    logic [16:0]                          eff_cnt, cnt_m1;
    logic                                 is_last;
    logic                                 in_fire, cfg_wr, out_load;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign uc       = lepg_pkg::UCODE[step_reg];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg  <= lepg_pkg::SIGMA_RST;
            beta_reg   <= lepg_pkg::BETA_RST;
            rho_reg    <= lepg_pkg::RHO_RST;
            dt_reg     <= lepg_pkg::DT_RST;
            cstart_reg <= lepg_pkg::COLOR_RST;
            cend_reg   <= lepg_pkg::COLOR_RST;
            rscale_reg <= lepg_pkg::RSCALE_RST;
            count_reg  <= lepg_pkg::COUNT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                lepg_pkg::REG_SIGMA:  sigma_reg  <= pwdata;
                lepg_pkg::REG_BETA:   beta_reg   <= pwdata;
                lepg_pkg::REG_RHO:    rho_reg    <= pwdata;
                lepg_pkg::REG_DT:     dt_reg     <= pwdata[30:0];
                lepg_pkg::REG_CSTART: cstart_reg <= pwdata[23:0];
                lepg_pkg::REG_CEND:   cend_reg   <= pwdata[23:0];
                lepg_pkg::REG_RSCALE: rscale_reg <= pwdata;
                lepg_pkg::REG_COUNT:  count_reg  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[4:2])
            lepg_pkg::REG_SIGMA:  prdata = sigma_reg;
            lepg_pkg::REG_BETA:   prdata = beta_reg;
            lepg_pkg::REG_RHO:    prdata = rho_reg;
            lepg_pkg::REG_DT:     prdata = {1'b0, dt_reg};
            lepg_pkg::REG_CSTART: prdata = {8'd0, cstart_reg};
            lepg_pkg::REG_CEND:   prdata = {8'd0, cend_reg};
            lepg_pkg::REG_RSCALE: prdata = rscale_reg;
            lepg_pkg::REG_COUNT:  prdata = {15'd0, count_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // Effective point count and the last-point test.
    always_comb
    begin
        if (count_reg == 17'd0)
        begin
            eff_cnt = 17'd1;
        end
        else if (count_reg > MaxCnt)
        begin
            eff_cnt = MaxCnt;
        end
        else
        begin
            eff_cnt = count_reg;
        end
        cnt_m1  = eff_cnt - 17'd1;
        is_last = ({1'b0, idx_reg} >= cnt_m1);
    end

    // Color channel differences, end minus start.
    assign dr = $signed({1'b0, cend_reg[23:16]}) - $signed({1'b0, cstart_reg[23:16]});
    assign dg = $signed({1'b0, cend_reg[15:8]})  - $signed({1'b0, cstart_reg[15:8]});
    assign db = $signed({1'b0, cend_reg[7:0]})   - $signed({1'b0, cstart_reg[7:0]});

    // Q8.24 view of the product: floor shift by 24, then saturate.
    assign q_val = lepg_pkg::sat32(prod_reg[65:24]);

    // Operand source bus, every entry 33 bits wide and read as signed.
    always_comb
    begin
        src_bus                       = '0;
        src_bus[lepg_pkg::SRC_ZERO]   = 33'd0;
        src_bus[lepg_pkg::SRC_X]      = {cur_x_reg[31], cur_x_reg};
        src_bus[lepg_pkg::SRC_Y]      = {cur_y_reg[31], cur_y_reg};
        src_bus[lepg_pkg::SRC_Z]      = {cur_z_reg[31], cur_z_reg};
        src_bus[lepg_pkg::SRC_T0]     = {t0_reg[31], t0_reg};
        src_bus[lepg_pkg::SRC_T1]     = {t1_reg[31], t1_reg};
        src_bus[lepg_pkg::SRC_T2]     = {t2_reg[31], t2_reg};
        src_bus[lepg_pkg::SRC_SIGMA]  = {sigma_reg[31], sigma_reg};
        src_bus[lepg_pkg::SRC_BETA]   = {beta_reg[31], beta_reg};
        src_bus[lepg_pkg::SRC_RHO]    = {rho_reg[31], rho_reg};
        src_bus[lepg_pkg::SRC_DT]     = {2'b00, dt_reg};
        src_bus[lepg_pkg::SRC_RS]     = {1'b0, rscale_reg};
        src_bus[lepg_pkg::SRC_IDX]    = {17'd0, idx_reg};
        src_bus[lepg_pkg::SRC_DR]     = {{24{dr[8]}}, dr};
        src_bus[lepg_pkg::SRC_DG]     = {{24{dg[8]}}, dg};
        src_bus[lepg_pkg::SRC_DB]     = {{24{db[8]}}, db};
        src_bus[lepg_pkg::SRC_C1R]    = {25'd0, cstart_reg[23:16]};
        src_bus[lepg_pkg::SRC_C1G]    = {25'd0, cstart_reg[15:8]};
        src_bus[lepg_pkg::SRC_C1B]    = {25'd0, cstart_reg[7:0]};
        src_bus[lepg_pkg::SRC_Q]      = {q_val[31], q_val};
        src_bus[lepg_pkg::SRC_P]      = prod_reg[32:0];
        src_bus[lepg_pkg::SRC_R]      = prod_reg[64:32];
    end

    assign mul_a_val = $signed(src_bus[uc.mul_a]);
    assign mul_b_val = $signed(src_bus[uc.mul_b]);
    assign alu_a_val = $signed(src_bus[uc.alu_a]);
    assign alu_b_val = $signed(src_bus[uc.alu_b]);

    // Saturating adder.
    always_comb
    begin
        case (uc.alu_op)
            lepg_pkg::ALU_SUB: alu_sum = 34'(alu_a_val) - 34'(alu_b_val);
            default:           alu_sum = 34'(alu_a_val) + 34'(alu_b_val);
        endcase
        alu_sat = lepg_pkg::sat32(42'(alu_sum));
    end

    // Shared multiplier with its product register.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RUN && uc.mul_en)
        begin
            prod_reg <= 66'(mul_a_val) * 66'(mul_b_val);
        end
    end

    // Sequencer: the program runs to its final word, then hands off.
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (uc.fin)
                begin
                    state_next = ST_OUT;
                    step_next  = 4'd0;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = 4'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Trajectory state and index: restart load, write-back, index advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= lepg_pkg::INIT_X;
            cur_y_reg <= 32'sd0;
            cur_z_reg <= 32'sd0;
            idx_reg   <= 16'd0;
        end
        else if (in_fire && restart)
        begin
            cur_x_reg <= lepg_pkg::INIT_X;
            cur_y_reg <= 32'sd0;
            cur_z_reg <= 32'sd0;
            idx_reg   <= 16'd0;
        end
        else if (state_reg == ST_RUN)
        begin
            case (uc.dst)
                lepg_pkg::DST_X: cur_x_reg <= alu_sat;
                lepg_pkg::DST_Y: cur_y_reg <= alu_sat;
                lepg_pkg::DST_Z: cur_z_reg <= alu_sat;
                default: ;
            endcase
        end
        else if (out_load && !is_last)
        begin
            idx_reg <= idx_reg + 16'd1;
        end
    end

    // Scratch and color write-back.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RUN)
        begin
            case (uc.dst)
                lepg_pkg::DST_T0:    t0_reg <= alu_sat;
                lepg_pkg::DST_T1:    t1_reg <= alu_sat;
                lepg_pkg::DST_T2:    t2_reg <= alu_sat;
                lepg_pkg::DST_RED:   cr_reg <= lepg_pkg::clamp8(alu_sum);
                lepg_pkg::DST_GREEN: cg_reg <= lepg_pkg::clamp8(alu_sum);
                lepg_pkg::DST_BLUE:  cb_reg <= lepg_pkg::clamp8(alu_sum);
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pos_x_reg <= cur_x_reg;
            pos_y_reg <= cur_y_reg;
            pos_z_reg <= cur_z_reg;
            red_reg   <= cr_reg;
            green_reg <= cg_reg;
            blue_reg  <= cb_reg;
            index_reg <= idx_reg;
            last_reg  <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign pos_z      = pos_z_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign step_index = index_reg;
    assign last_point = last_reg;

    // The step counter moves only while the program runs.
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_RUN |-> step_reg == 4'd0)
        else $error("step counter nonzero outside the program");

    // A new result appears only from the hand-off state.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared without a finished program");

    // An accepted transfer starts the program on the next cycle.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_RUN && step_reg == 4'd0))
        else $error("accepted transfer did not start the program");

endmodule

// ----- tb/lorenz_euler_point_generator_core_tb.sv -----
// Testbench for lorenz_euler_point_generator_core: directed and random ticks
// and APB setups; each output point checked against an in-bench fixed-point
// Euler predictor. Depends on lepg_pkg and the core RTL.
`timescale 1ns / 1ps

module lorenz_euler_point_generator_core_tb;

    localparam int PointLimit = 65536;
    localparam int QuietLimit = 2000;
    localparam int LongHold   = 300;
    localparam int RandomTicks = 850;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [15:0]        idx;
        logic               last;
    } point_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic restart = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [15:0] step_index;
    logic last_point;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [lepg_pkg::AddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Mirror of the configuration registers.
    logic signed [31:0] cfg_sigma = lepg_pkg::SIGMA_RST;
    logic signed [31:0] cfg_beta = lepg_pkg::BETA_RST;
    logic signed [31:0] cfg_rho = lepg_pkg::RHO_RST;
    logic [30:0] cfg_dt = lepg_pkg::DT_RST;
    logic [23:0] cfg_cstart = lepg_pkg::COLOR_RST;
    logic [23:0] cfg_cend = lepg_pkg::COLOR_RST;
    logic [31:0] cfg_rscale = lepg_pkg::RSCALE_RST;
    logic [16:0] cfg_count = lepg_pkg::COUNT_RST;

    // Predicted trajectory state.
    logic signed [31:0] traj_x = lepg_pkg::INIT_X;
    logic signed [31:0] traj_y = '0;
    logic signed [31:0] traj_z = '0;
    logic [15:0] traj_idx = '0;

    bit     tick_queue[$];
    point_t pending_points[$];
    int     ticks_taken = 0;
    int     results_seen = 0;
    int     mismatches = 0;
    logic   tick_taken = 1'b0;
    int     src_gap = 0;
    int     snk_gap = 0;
    bit     src_idle_on = 1'b0;
    bit     snk_idle_on = 1'b0;
    int     hold_req_count = 0;
    int     hold_served = 0;
    int     quiet_cycles = 0;

    lorenz_euler_point_generator_core #(
        .MAX_POINTS(PointLimit)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .restart(restart),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .red(red),
        .green(green),
        .blue(blue),
        .step_index(step_index),
        .last_point(last_point),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturate to the 32-bit signed range.
    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sh7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Q8.24 product, floored, then saturated.
    function automatic logic signed [31:0] fix_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip32(p >>> 24);
    endfunction

    // One color channel of the ramp at point index i, clamped to 0..255.
    function automatic logic [7:0] ramp_channel(input logic [7:0] c1, input logic [7:0] c2,
                                                input logic [15:0] i);
        longint t;
        longint v;
        t = longint'(i) * longint'(cfg_rscale);
        v = longint'(c1) + (((longint'(c2) - longint'(c1)) * t) >>> 32);
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 255)
        begin
            v = 255;
        end
        return v[7:0];
    endfunction

    // Advance the predicted trajectory by one Euler step and return the point.
    function automatic point_t next_point(input logic rs);
        point_t p;
        longint cnt;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [15:0] i;
        if (rs)
        begin
            traj_x = lepg_pkg::INIT_X;
            traj_y = '0;
            traj_z = '0;
            traj_idx = '0;
        end
        cnt = longint'(cfg_count);
        if (cnt < 1)
        begin
            cnt = 1;
        end
        if (cnt > PointLimit)
        begin
            cnt = PointLimit;
        end
        // All three derivatives use the old position.
        dx = fix_mul(cfg_sigma, clip32(longint'(traj_y) - longint'(traj_x)));
        dx = fix_mul(dx, cfg_dt);
        dy = clip32(longint'(fix_mul(traj_x, clip32(longint'(cfg_rho) - longint'(traj_z))))
                    - longint'(traj_y));
        dy = fix_mul(dy, cfg_dt);
        dz = clip32(longint'(fix_mul(traj_x, traj_y)) - longint'(fix_mul(cfg_beta, traj_z)));
        dz = fix_mul(dz, cfg_dt);
        traj_x = clip32(longint'(traj_x) + longint'(dx));
        traj_y = clip32(longint'(traj_y) + longint'(dy));
        traj_z = clip32(longint'(traj_z) + longint'(dz));
        i = traj_idx;
        p.x = traj_x;
        p.y = traj_y;
        p.z = traj_z;
        p.r = ramp_channel(cfg_cstart[23:16], cfg_cend[23:16], i);
        p.g = ramp_channel(cfg_cstart[15:8], cfg_cend[15:8], i);
        p.b = ramp_channel(cfg_cstart[7:0], cfg_cend[7:0], i);
        p.idx = i;
        p.last = (longint'(i) >= cnt - 1);
        // The index saturates at the last point of the run.
        if (!p.last)
        begin
            traj_idx = i + 16'd1;
        end
        return p;
    endfunction

    // APB write: setup cycle, then access cycle; the mirror follows the write.
    task automatic cfg_write(input lepg_pkg::reg_idx_t ri, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {ri, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (ri)
            lepg_pkg::REG_SIGMA:  cfg_sigma = val;
            lepg_pkg::REG_BETA:   cfg_beta = val;
            lepg_pkg::REG_RHO:    cfg_rho = val;
            lepg_pkg::REG_DT:     cfg_dt = val[30:0];
            lepg_pkg::REG_CSTART: cfg_cstart = val[23:0];
            lepg_pkg::REG_CEND:   cfg_cend = val[23:0];
            lepg_pkg::REG_RSCALE: cfg_rscale = val;
            lepg_pkg::REG_COUNT:  cfg_count = val[16:0];
            default:    ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait until every queued tick has been sent and every point checked.
    task automatic wait_idle();
        while (tick_queue.size() != 0 || in_valid || results_seen != ticks_taken)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0100_0000;
            default: return $urandom();
        endcase
    endfunction

    // Write a fresh random setup to every register.
    task automatic load_setup(input int kind);
        logic [31:0] s;
        logic [31:0] bt;
        logic [31:0] rh;
        logic [31:0] dt;
        logic [31:0] cnt;
        logic [31:0] rs;
        int eff;
        case (kind)
            0, 1, 2:
            begin
                // Near the classic coefficients, so trajectories stay bounded.
                s = lepg_pkg::SIGMA_RST + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
                bt = lepg_pkg::BETA_RST + $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
                rh = lepg_pkg::RHO_RST + $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
                dt = $urandom_range(1, 32'h0010_0000) | ($urandom_range(0, 1) << 31);
            end
            3:
            begin
                s = $urandom();
                bt = $urandom();
                rh = $urandom();
                dt = $urandom();
            end
            default:
            begin
                s = corner_word();
                bt = corner_word();
                rh = corner_word();
                dt = corner_word();
            end
        endcase
        case ($urandom_range(0, 5))
            0:       cnt = $urandom();
            1:       cnt = 32'd0;
            2:       cnt = 32'd1;
            default: cnt = $urandom_range(2, 48);
        endcase
        eff = (cnt[16:0] == 0) ? 1 : ((cnt[16:0] > PointLimit) ? PointLimit : cnt[16:0]);
        case ($urandom_range(0, 3))
            0:       rs = $urandom();
            1:       rs = corner_word();
            default: rs = 32'hFFFF_FFFF / eff;
        endcase
        cfg_write(lepg_pkg::REG_SIGMA, s);
        cfg_write(lepg_pkg::REG_BETA, bt);
        cfg_write(lepg_pkg::REG_RHO, rh);
        cfg_write(lepg_pkg::REG_DT, dt);
        cfg_write(lepg_pkg::REG_CSTART, $urandom());
        cfg_write(lepg_pkg::REG_CEND, $urandom());
        cfg_write(lepg_pkg::REG_RSCALE, rs);
        cfg_write(lepg_pkg::REG_COUNT, cnt);
    endtask

    // Sender: present queued ticks, holding each until its transfer.
    always @(negedge clk)
    begin
        if (!in_valid || tick_taken)
        begin
            if (src_gap > 0)
            begin
                in_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (tick_queue.size() != 0 && src_idle_on && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                src_gap <= $urandom_range(0, 15);
            end
            else if (tick_queue.size() != 0)
            begin
                in_valid <= 1'b1;
                restart <= tick_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Each accepted tick yields exactly one predicted point.
    always @(posedge clk)
    begin
        tick_taken <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            pending_points.push_back(next_point(restart));
            ticks_taken <= ticks_taken + 1;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_served != hold_req_count)
        begin
            hold_served <= hold_req_count;
            out_ready <= 1'b0;
            snk_gap <= LongHold;
        end
        else if (snk_gap > 0)
        begin
            out_ready <= 1'b0;
            snk_gap <= snk_gap - 1;
        end
        else if (snk_idle_on && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            snk_gap <= $urandom_range(0, 15);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare each output transfer with the oldest predicted point.
    always @(posedge clk)
    begin : check_points
        point_t want;
        point_t got;
        if (out_valid && out_ready)
        begin
            got = {pos_x, pos_y, pos_z, red, green, blue, step_index, last_point};
            if (pending_points.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("unexpected point: x=%h y=%h z=%h rgb=%h%h%h idx=%0d last=%b",
                             got.x, got.y, got.z, got.r, got.g, got.b, got.idx, got.last);
                end
                mismatches = mismatches + 1;
            end
            else
            begin
                want = pending_points.pop_front();
                results_seen <= results_seen + 1;
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                    || got.r !== want.r || got.g !== want.g || got.b !== want.b
                    || got.idx !== want.idx || got.last !== want.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("point mismatch at %0t", $realtime);
                        $display("  expected x=%h y=%h z=%h rgb=%h%h%h idx=%0d last=%b",
                                 want.x, want.y, want.z, want.r, want.g, want.b,
                                 want.idx, want.last);
                        $display("  actual   x=%h y=%h z=%h rgb=%h%h%h idx=%0d last=%b",
                                 got.x, got.y, got.z, got.r, got.g, got.b,
                                 got.idx, got.last);
                    end
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: directed setups first, then random setup phases.
    initial
    begin : stimulus
        int sent;
        int phase_no;
        int n;
        int odds;
        bit final_part;
        logic [1:0] idle_mode;
        sent = 0;
        phase_no = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: step from the reset position, then restart.
        @(posedge clk);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        wait_idle();

        // Extreme coefficients and step: positions saturate; a count of zero acts as one.
        cfg_write(lepg_pkg::REG_SIGMA, 32'h7FFF_FFFF);
        cfg_write(lepg_pkg::REG_BETA, 32'h8000_0000);
        cfg_write(lepg_pkg::REG_RHO, 32'h7FFF_FFFF);
        cfg_write(lepg_pkg::REG_DT, 32'hFFFF_FFFF);
        cfg_write(lepg_pkg::REG_CSTART, 32'hFFFF_00FF);
        cfg_write(lepg_pkg::REG_CEND, 32'h0000_FF00);
        cfg_write(lepg_pkg::REG_RSCALE, 32'h8000_0000);
        cfg_write(lepg_pkg::REG_COUNT, 32'd0);
        @(posedge clk);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        wait_idle();

        // Lowest sigma and rho, largest beta, zero step, oversized count, ramp overshoot.
        cfg_write(lepg_pkg::REG_SIGMA, 32'h8000_0000);
        cfg_write(lepg_pkg::REG_BETA, 32'h7FFF_FFFF);
        cfg_write(lepg_pkg::REG_RHO, 32'h8000_0000);
        cfg_write(lepg_pkg::REG_DT, 32'h8000_0000);
        cfg_write(lepg_pkg::REG_CSTART, 32'h0000_FF00);
        cfg_write(lepg_pkg::REG_CEND, 32'h00FF_00FF);
        cfg_write(lepg_pkg::REG_RSCALE, 32'hFFFF_FFFF);
        cfg_write(lepg_pkg::REG_COUNT, 32'h0001_FFFF);
        @(posedge clk);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        wait_idle();

        // Classic coefficients, short run: the index saturates at the last point.
        cfg_write(lepg_pkg::REG_SIGMA, lepg_pkg::SIGMA_RST);
        cfg_write(lepg_pkg::REG_BETA, lepg_pkg::BETA_RST);
        cfg_write(lepg_pkg::REG_RHO, lepg_pkg::RHO_RST);
        cfg_write(lepg_pkg::REG_DT, lepg_pkg::DT_RST);
        cfg_write(lepg_pkg::REG_CSTART, 32'h0010_2030);
        cfg_write(lepg_pkg::REG_CEND, 32'h00F0_E0D0);
        cfg_write(lepg_pkg::REG_RSCALE, 32'hFFFF_FFFF / 8);
        cfg_write(lepg_pkg::REG_COUNT, 32'd8);
        @(posedge clk);
        tick_queue.push_back(1'b1);
        repeat (9) tick_queue.push_back(1'b0);
        wait_idle();

        // Count lowered mid-run: the index holds and the last flag stays set.
        cfg_write(lepg_pkg::REG_COUNT, 32'd4);
        @(posedge clk);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        wait_idle();

        // Random phases; the final one runs without any idling.
        while (sent < RandomTicks)
        begin
            n = $urandom_range(40, 110);
            final_part = (sent + n >= RandomTicks);
            load_setup($urandom_range(0, 4));
            @(posedge clk);
            idle_mode = $urandom_range(0, 3);
            src_idle_on = idle_mode[0] && !final_part && phase_no != 1;
            snk_idle_on = idle_mode[1] && !final_part;
            odds = ($urandom_range(0, 4) == 0) ? 2 : 40;
            for (int k = 0; k < n; k++)
            begin
                if (k == 0)
                begin
                    tick_queue.push_back($urandom_range(0, 3) != 0);
                end
                else
                begin
                    tick_queue.push_back($urandom_range(1, odds) == 1);
                end
            end
            // Back-pressure: the receiver holds off while the sender keeps offering.
            if (phase_no == 1)
            begin
                hold_req_count = hold_req_count + 1;
            end
            sent = sent + n;
            phase_no = phase_no + 1;
            wait_idle();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_points.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
